[hw/rtl/grid_refine_trapezoid_weights_macros.svh]
// assertion helpers, empty when synthesising
`ifndef GRID_REFINE_TRAPEZOID_WEIGHTS_MACROS_SVH
`define GRID_REFINE_TRAPEZOID_WEIGHTS_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GRTW_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("grtw assertion failed");
// next-cycle implication
`define GRTW_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("grtw assertion failed");
`else
`define GRTW_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define GRTW_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

[hw/rtl/grtw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package grtw_pkg;

  localparam int DATA_W      = 32;
  localparam int WT_W        = 31;
  localparam int STAT_W      = 3;
  localparam int MAX_SUB_DEF = 32;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_ORDER    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_WID = 3'd2;
  localparam logic [STAT_W-1:0] STAT_SAT      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FEW      = 3'd4;

  typedef struct packed {
    logic signed [DATA_W-1:0] point;
    logic [DATA_W-1:0]        max_width;
    logic                     width_infinite;
    logic                     final_point;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] refined_point;
    logic [WT_W-1:0]          weight;
    logic                     grid_end;
    logic                     run_last;
    logic [STAT_W-1:0]        status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_N,
    S_DIV_W,
    S_EMIT,
    S_FINAL,
    S_ERROR
  } state_t;

  typedef enum logic [1:0] {
    TR_NONE,
    TR_FIRST,
    TR_ADV,
    TR_CLEAR
  } track_op_t;

  typedef struct packed {
    track_op_t                op;
    logic signed [DATA_W-1:0] q;
  } track_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/grtw_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module grtw_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [grtw_pkg::DATA_W-1:0] dividend,
  input  wire logic [grtw_pkg::DATA_W-1:0] divisor,
  output logic                             busy,
  output logic                             done,
  output logic [grtw_pkg::DATA_W-1:0]      quotient,
  output logic [grtw_pkg::DATA_W-1:0]      remainder
);
  import grtw_pkg::*;

  localparam int CW = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [DATA_W:0]   trial;
  logic [DATA_W+1:0] diff;
  logic              ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[DATA_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvs_r};
    ge    = !diff[DATA_W+1];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

[hw/rtl/grtw_track.sv]
`timescale 1ns / 1ps
`default_nettype none
module grtw_track (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire grtw_pkg::track_ctl_t               ctl,
  output logic signed [grtw_pkg::DATA_W-1:0]      pending,
  output logic [grtw_pkg::WT_W-1:0]               adv_weight,
  output logic [grtw_pkg::WT_W-1:0]               fin_weight
);
  import grtw_pkg::*;

  logic signed [DATA_W-1:0] pend_r, pend_nxt;
  logic signed [DATA_W-1:0] pbp_r, pbp_nxt;
  logic [1:0]               cnt_r, cnt_nxt;
  logic signed [DATA_W-1:0] left;

  // half the distance between two points, clamped at zero
  function automatic logic [WT_W-1:0] half_gap(input logic signed [DATA_W-1:0] right,
                                               input logic signed [DATA_W-1:0] lft);
    logic signed [DATA_W:0] g;
    g = {right[DATA_W-1], right} - {lft[DATA_W-1], lft};
    return g[DATA_W] ? '0 : g[DATA_W-1:1];
  endfunction

  // left neighbour is the point itself at the grid's left edge
  always_comb begin
    left       = (cnt_r == 2'd2) ? pbp_r : pend_r;
    adv_weight = half_gap(ctl.q, left);
    fin_weight = half_gap(pend_r, pbp_r);
    pending    = pend_r;
  end

  always_comb begin
    pend_nxt = pend_r;
    pbp_nxt  = pbp_r;
    cnt_nxt  = cnt_r;
    unique case (ctl.op)
      TR_NONE: begin
      end
      TR_FIRST: begin
        pend_nxt = ctl.q;
        pbp_nxt  = '0;
        cnt_nxt  = 2'd1;
      end
      TR_ADV: begin
        pbp_nxt  = pend_r;
        pend_nxt = ctl.q;
        cnt_nxt  = 2'd2;
      end
      TR_CLEAR: begin
        pend_nxt = '0;
        pbp_nxt  = '0;
        cnt_nxt  = 2'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pbp_r  <= '0;
      cnt_r  <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
      pbp_r  <= pbp_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/grid_refine_trapezoid_weights.sv]
// sequence: a first point (not final) is accepted and gives no item; an interval runs
// the bit-serial n = ceil(d / max_width) division on the shared serial divider, then
// w = d / n (both skipped for infinite width, the second for n = 1), then emits its n
// items one a cycle while the output does not stall, plus the right edge item on a
// final point. a new input item is taken only once all items of the last are issued;
// a stall on the output holds emission for as long as it lasts. reset: synchronous
// active-low rst_n returns to an empty grid with no item pending.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_refine_trapezoid_weights_macros.svh"
module grid_refine_trapezoid_weights #(
  parameter int MAX_SUB = grtw_pkg::MAX_SUB_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire grtw_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output grtw_pkg::out_item_t       out_data
);
  import grtw_pkg::*;

  localparam int NW = $clog2(MAX_SUB + 1);

  state_t                   state_r, state_nxt;
  logic signed [DATA_W-1:0] prev_r, prev_nxt;
  logic                     have_prev_r, have_prev_nxt;
  logic signed [DATA_W-1:0] pt_r, pt_nxt;
  logic                     fin_r, fin_nxt;
  logic [DATA_W-1:0]        d_r, d_nxt;
  logic [NW-1:0]            n_r, n_nxt;
  logic [NW-1:0]            k_r, k_nxt;
  logic [DATA_W-1:0]        w_r, w_nxt;
  logic signed [DATA_W-1:0] pos_r, pos_nxt;
  logic [STAT_W-1:0]        stat_r, stat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r, out_nxt;

  logic                     accept;
  logic                     out_free;
  logic signed [DATA_W:0]   d_full;
  logic                     sat;
  logic [NW-1:0]            n_calc;

  logic                     div_start;
  logic [DATA_W-1:0]        div_dividend;
  logic [DATA_W-1:0]        div_divisor;
  logic                     div_busy;
  logic                     div_done;
  logic [DATA_W-1:0]        div_quo;
  logic [DATA_W-1:0]        div_rem;

  track_ctl_t               trk_ctl;
  logic signed [DATA_W-1:0] trk_pending;
  logic [WT_W-1:0]          trk_adv_wt;
  logic [WT_W-1:0]          trk_fin_wt;

  grtw_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  grtw_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (trk_ctl),
    .pending    (trk_pending),
    .adv_weight (trk_adv_wt),
    .fin_weight (trk_fin_wt)
  );

  // handshake and interval length
  always_comb begin
    in_ready = (state_r == S_IDLE);
    accept   = in_valid && in_ready;
    out_free = !out_valid_r || out_ready;
    d_full   = {in_data.point[DATA_W-1], in_data.point} - {prev_r[DATA_W-1], prev_r};
  end

  // subdivision count from the first division, clamped
  always_comb begin
    sat    = (div_quo > DATA_W'(MAX_SUB)) ||
             ((div_quo == DATA_W'(MAX_SUB)) && (div_rem != '0));
    n_calc = sat ? NW'(MAX_SUB) : (div_quo[NW-1:0] + NW'(div_rem != '0));
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    pt_nxt        = pt_r;
    fin_nxt       = fin_r;
    d_nxt         = d_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    pos_nxt       = pos_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    div_start     = 1'b0;
    div_dividend  = d_r;
    div_divisor   = DATA_W'(n_calc);
    trk_ctl.op    = TR_NONE;
    trk_ctl.q     = pos_r + $signed(w_r);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pt_nxt  = in_data.point;
          fin_nxt = in_data.final_point;
          d_nxt   = d_full[DATA_W-1:0];
          pos_nxt = prev_r;
          k_nxt   = NW'(1);
          if (!have_prev_r) begin
            if (in_data.final_point) begin
              stat_nxt  = STAT_FEW;
              state_nxt = S_ERROR;
            end else begin
              trk_ctl.op    = TR_FIRST;
              trk_ctl.q     = in_data.point;
              prev_nxt      = in_data.point;
              have_prev_nxt = 1'b1;
            end
          end else if (d_full[DATA_W] || (d_full == '0)) begin
            stat_nxt  = STAT_ORDER;
            state_nxt = S_ERROR;
          end else if (in_data.width_infinite) begin
            prev_nxt  = in_data.point;
            n_nxt     = NW'(1);
            stat_nxt  = STAT_OK;
            state_nxt = S_EMIT;
          end else if (in_data.max_width == '0) begin
            stat_nxt  = STAT_ZERO_WID;
            state_nxt = S_ERROR;
          end else begin
            prev_nxt     = in_data.point;
            div_start    = 1'b1;
            div_dividend = d_full[DATA_W-1:0];
            div_divisor  = in_data.max_width;
            state_nxt    = S_DIV_N;
          end
        end
      end
      S_DIV_N: begin
        if (div_done) begin
          n_nxt    = n_calc;
          stat_nxt = sat ? STAT_SAT : STAT_OK;
          if (n_calc == NW'(1)) begin
            state_nxt = S_EMIT;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV_W;
          end
        end
      end
      S_DIV_W: begin
        if (div_done) begin
          w_nxt     = div_quo;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_nxt.status    = stat_r;
          out_nxt.grid_end  = 1'b0;
          out_nxt.refined_point = trk_pending;
          trk_ctl.op        = TR_ADV;
          if (k_r < n_r) begin
            // intermediate point: previous point plus k sub-widths
            out_nxt.weight   = trk_adv_wt;
            out_nxt.run_last = 1'b0;
            pos_nxt          = trk_ctl.q;
            k_nxt            = k_r + 1'b1;
          end else begin
            // interval end is the input point itself
            trk_ctl.q        = pt_r;
            out_nxt.weight   = trk_adv_wt;
            out_nxt.run_last = !fin_r;
            state_nxt        = fin_r ? S_FINAL : S_IDLE;
          end
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.refined_point = trk_pending;
          out_nxt.weight        = trk_fin_wt;
          out_nxt.grid_end      = 1'b1;
          out_nxt.run_last      = 1'b1;
          out_nxt.status        = stat_r;
          trk_ctl.op            = TR_CLEAR;
          prev_nxt              = '0;
          have_prev_nxt         = 1'b0;
          state_nxt             = S_IDLE;
        end
      end
      S_ERROR: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.refined_point = '0;
          out_nxt.weight        = '0;
          out_nxt.grid_end      = 1'b1;
          out_nxt.run_last      = 1'b1;
          out_nxt.status        = stat_r;
          trk_ctl.op            = TR_CLEAR;
          prev_nxt              = '0;
          have_prev_nxt         = 1'b0;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pt_r   <= pt_nxt;
    fin_r  <= fin_nxt;
    d_r    <= d_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    w_r    <= w_nxt;
    pos_r  <= pos_nxt;
    stat_r <= stat_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // error items close the grid with an empty point
  `GRTW_ASSERT_IMP(a_err_shape, clk, rst_n,
    out_valid && (out_data.status == STAT_ORDER || out_data.status == STAT_ZERO_WID ||
                  out_data.status == STAT_FEW),
    out_data.grid_end && out_data.run_last && (out_data.weight == '0))
  // the right edge item is always the last of its input item
  `GRTW_ASSERT_IMP(a_end_last, clk, rst_n, out_valid && out_data.grid_end, out_data.run_last)
  // while waiting on a division the divider is running or just finished
  `GRTW_ASSERT_IMP(a_div_live, clk, rst_n, state_r == S_DIV_N || state_r == S_DIV_W,
    div_busy || div_done)
  // the sub-width division hands over to emission
  `GRTW_ASSERT_NXT(a_div_emit, clk, rst_n, state_r == S_DIV_W && div_done, state_r == S_EMIT)

endmodule
`default_nettype wire

[tb/tb_grid_refine_trapezoid_weights.sv]
`timescale 1ns / 1ps
module tb_grid_refine_trapezoid_weights;
  import grtw_pkg::*;

  localparam int SUB_LIMIT     = MAX_SUB_DEF;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int STUCK_LIMIT   = 3000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  grid_refine_trapezoid_weights #(
    .MAX_SUB(SUB_LIMIT)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // grid points waiting to be driven, refined points due out
  in_item_t  grid_pts_q[$];
  out_item_t refined_due_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int mismatch_cnt = 0;

  // predictor state for the grid in progress
  logic signed [DATA_W-1:0] prev_pt = '0;
  logic                     have_prev = 1'b0;
  logic signed [DATA_W-1:0] pend_pt = '0;
  logic signed [DATA_W-1:0] before_pend = '0;
  int                       seen_cnt = 0;

  function automatic logic [WT_W-1:0] half_span(longint hi_pt, longint lo_pt);
    longint g;
    g = hi_pt - lo_pt;
    if (g < 0) g = 0;
    return g[WT_W:1];
  endfunction

  function automatic void reset_grid();
    prev_pt = '0;
    have_prev = 1'b0;
    pend_pt = '0;
    before_pend = '0;
    seen_cnt = 0;
  endfunction

  function automatic out_item_t grid_abort(logic [STAT_W-1:0] st);
    out_item_t r;
    r = '0;
    r.grid_end = 1'b1;
    r.run_last = 1'b1;
    r.status = st;
    reset_grid();
    return r;
  endfunction

  // emit the pending point now that its right neighbour q is known
  function automatic out_item_t advance_pending(longint q, logic [STAT_W-1:0] st);
    out_item_t r;
    longint lo_pt;
    lo_pt = (seen_cnt >= 2) ? longint'(before_pend) : longint'(pend_pt);
    r = '0;
    r.refined_point = pend_pt;
    r.weight = half_span(q, lo_pt);
    r.status = st;
    before_pend = pend_pt;
    pend_pt = q[DATA_W-1:0];
    seen_cnt = 2;
    return r;
  endfunction

  // refine the interval closed by one grid point and queue its outputs
  function automatic void refine_interval(in_item_t it);
    out_item_t         res[$];
    out_item_t         r;
    longint            p;
    longint            prev;
    longint            d;
    longint unsigned   n;
    longint unsigned   w;
    longint unsigned   mw;
    longint unsigned   k;
    logic [STAT_W-1:0] st;
    p = longint'($signed(it.point));
    mw = longint'(it.max_width);
    st = STAT_OK;
    if (!have_prev) begin
      if (it.final_point) begin
        res.push_back(grid_abort(STAT_FEW));
      end else begin
        prev_pt = it.point;
        have_prev = 1'b1;
        pend_pt = it.point;
        before_pend = '0;
        seen_cnt = 1;
      end
    end else begin
      prev = longint'(prev_pt);
      d = p - prev;
      if (d <= 0) begin
        res.push_back(grid_abort(STAT_ORDER));
      end else if (!it.width_infinite && mw == 0) begin
        res.push_back(grid_abort(STAT_ZERO_WID));
      end else begin
        n = 1;
        if (!it.width_infinite) begin
          n = (longint'(d) + mw - 1) / mw;
          if (n > SUB_LIMIT) begin
            n = SUB_LIMIT;
            st = STAT_SAT;
          end
        end
        w = longint'(d) / n;
        for (k = 1; k < n; k++) res.push_back(advance_pending(prev + longint'(k * w), st));
        res.push_back(advance_pending(p, st));
        prev_pt = it.point;
        // right edge point of the grid
        if (it.final_point) begin
          r = '0;
          r.refined_point = pend_pt;
          r.weight = half_span(longint'(pend_pt), longint'(before_pend));
          r.grid_end = 1'b1;
          r.status = st;
          res.push_back(r);
          reset_grid();
        end
      end
    end
    if (res.size() != 0) begin
      r = res.pop_back();
      r.run_last = 1'b1;
      res.push_back(r);
    end
    foreach (res[i]) refined_due_q.push_back(res[i]);
  endfunction

  task automatic add_point(logic [31:0] p, logic [31:0] mw, logic inf, logic fin);
    in_item_t it;
    it.point = p;
    it.max_width = mw;
    it.width_infinite = inf;
    it.final_point = fin;
    grid_pts_q.push_back(it);
  endtask

  // well-formed grid with random spacing and widths
  task automatic add_grid();
    int          npts;
    int          nt;
    int          sel;
    int          i;
    longint      pos;
    longint      d;
    logic [31:0] mw;
    logic        inf;
    npts = $urandom_range(7, 2);
    pos = longint'($signed($urandom())) / 2;
    add_point(pos[31:0], $urandom(), 1'($urandom_range(1)), 1'b0);
    for (i = 1; i < npts; i++) begin
      d = ($urandom_range(3) == 0) ? longint'($urandom_range(64, 1)) :
                                     longint'($urandom_range(1 << 20, 1));
      sel = $urandom_range(9);
      if (sel == 0) begin
        inf = 1'b1;
        mw = $urandom();
      end else begin
        inf = 1'b0;
        nt = (sel == 1) ? $urandom_range(200, 20) : $urandom_range(6, 1);
        mw = 32'((d + nt - 1) / nt);
      end
      pos += d;
      add_point(pos[31:0], mw, inf, i == npts - 1);
    end
  endtask

  // broken sequences and raw random items
  task automatic add_noise();
    logic [31:0] p;
    p = $urandom();
    case ($urandom_range(3))
      0: add_point(p, $urandom(), 1'($urandom_range(1)), 1'b1);
      1: begin
        add_point(p, $urandom(), 1'($urandom_range(1)), 1'b0);
        add_point(p - $urandom_range(1000), $urandom(), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
      2: begin
        add_point(p, $urandom(), 1'($urandom_range(1)), 1'b0);
        add_point(p + $urandom_range(1000, 1), '0, 1'b0, 1'($urandom_range(1)));
      end
      default: add_point(p, $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)));
    endcase
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) refine_interval(in_data);
      if (!in_valid || in_ready) begin
        if (grid_pts_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data <= grid_pts_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  int        hold_left = 0;
  int        holds_taken = 0;
  out_item_t due;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (refined_due_q.size() == 0) begin
          $error("unexpected item: refined_point %0d", $signed(out_data.refined_point));
          mismatch_cnt++;
        end else begin
          due = refined_due_q.pop_front();
          if (out_data.refined_point !== due.refined_point) begin
            $error("refined_point: expected %0d, got %0d",
                   $signed(due.refined_point), $signed(out_data.refined_point));
            mismatch_cnt++;
          end
          if (out_data.weight !== due.weight) begin
            $error("weight: expected %0d, got %0d", due.weight, out_data.weight);
            mismatch_cnt++;
          end
          if (out_data.grid_end !== due.grid_end) begin
            $error("grid_end: expected %0d, got %0d", due.grid_end, out_data.grid_end);
            mismatch_cnt++;
          end
          if (out_data.run_last !== due.run_last) begin
            $error("run_last: expected %0d, got %0d", due.run_last, out_data.run_last);
            mismatch_cnt++;
          end
          if (out_data.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_data.status);
            mismatch_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (holds_taken != holds_asked) begin
        holds_taken <= holds_asked;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles without any item moving
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb_grid_refine_trapezoid_weights: errors");
        $finish;
      end
    end
  end

  // one phase of random grids, then drain
  task automatic run_phase(int idle, int stall, int count, bit with_hold);
    int target;
    @(negedge clk);
    idle_pct = idle;
    stall_pct = stall;
    target = grid_pts_q.size() + count;
    while (grid_pts_q.size() < target) begin
      if ($urandom_range(99) < 85) add_grid();
      else add_noise();
    end
    if (with_hold) holds_asked++;
    while (grid_pts_q.size() != 0 || in_valid || refined_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    // lone final point
    add_point(32'd5, '0, 1'b0, 1'b1);
    // full range interval, widest weight
    add_point(32'h8000_0000, '0, 1'b1, 1'b0);
    add_point(32'h7fff_ffff, 32'hffff_ffff, 1'b0, 1'b1);
    // infinite width, plain split, saturated split
    add_point(32'd0, 32'hffff_ffff, 1'b0, 1'b0);
    add_point(32'h0001_0000, '0, 1'b1, 1'b0);
    add_point(32'h0003_0000, 32'h0000_8000, 1'b0, 1'b0);
    add_point(32'h0003_0064, 32'd1, 1'b0, 1'b0);
    add_point(32'h0005_0000, 32'h0000_7000, 1'b0, 1'b1);
    // equal point, then decreasing point
    add_point(32'd100, '0, 1'b0, 1'b0);
    add_point(32'd100, 32'd1, 1'b0, 1'b0);
    add_point(32'd100, '0, 1'b0, 1'b0);
    add_point(32'd50, 32'd1, 1'b0, 1'b0);
    // zero width
    add_point(32'd0, '0, 1'b0, 1'b0);
    add_point(32'd10, '0, 1'b0, 1'b0);
    // saturated split on a final point
    add_point(-32'sd1000, '0, 1'b0, 1'b0);
    add_point(32'd1000, 32'd7, 1'b0, 1'b1);
    // smallest step
    add_point(-32'sd7, '0, 1'b0, 1'b0);
    add_point(-32'sd6, 32'd1, 1'b0, 1'b1);
    // order error with refined points pending, then a lone final point
    add_point(32'd0, '0, 1'b0, 1'b0);
    add_point(32'd10, 32'd5, 1'b0, 1'b0);
    add_point(32'd5, 32'd3, 1'b0, 1'b0);
    add_point(32'd7, 32'd1, 1'b1, 1'b1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(0, 0, 30, 1'b0);
    run_phase(0, 0, 35, 1'b1);
    run_phase(72, 0, 30, 1'b0);
    run_phase(0, 72, 30, 1'b0);
    run_phase(20, 20, 30, 1'b0);

    if (mismatch_cnt == 0 && refined_due_q.size() == 0) begin
      $display("tb_grid_refine_trapezoid_weights: clean");
    end else begin
      $display("tb_grid_refine_trapezoid_weights: errors");
    end
    $finish;
  end

endmodule
